// ----- sv/hnt_pkg.sv -----
`default_nettype none

package hnt_pkg;

    typedef enum logic [2:0] {
        PH_HEAD   = 3'd0,
        PH_FRAME  = 3'd1,
        PH_CRC_LO = 3'd2,
        PH_CRC_HI = 3'd3,
        PH_TAIL   = 3'd4,
        PH_IDLE   = 3'd5
    } tx_phase_t;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  BYTE_MASK  = 8'hFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [2:0]  STUFF_RUN  = 3'd5;
    localparam logic [3:0]  BYTE_BITS  = 4'd8;

    localparam logic [7:0]  CFG_HEAD_FLAGS = 8'd0;
    localparam logic [7:0]  CFG_TAIL_FLAGS = 8'd1;

    localparam logic [7:0]  HEAD_FLAGS_RESET = 8'd1;
    localparam logic [7:0]  TAIL_FLAGS_RESET = 8'd1;

endpackage

`default_nettype wire

// ----- sv/hdlc_nrzi_transmitter.sv -----
`default_nettype none
// Each result beat is registered: it is valid in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while s_ready is high; one result beat per input beat.
// The output register frees as the result is taken, so s_ready follows m_ready.
// Reset (synchronous, active low): idle, CRC preset, level_now low (the m_line_* output
// registers are not reset), head_flags and tail_flags back to 1.

module hdlc_nrzi_transmitter (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_queue_empty,
    input  wire logic       s_queue_one_left,
    input  wire logic [7:0] s_queue_byte,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_line_level,
    output logic            m_line_active,
    output logic            m_pop_byte
);

    logic [7:0] head_flags_reg;
    logic [7:0] tail_flags_reg;

    hnt_pkg::tx_phase_t tx_phase_reg, tx_phase_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [3:0]  bits_sent_reg, bits_sent_next;
    logic [2:0]  ones_run_reg, ones_run_next;
    logic [15:0] crc_acc_reg, crc_acc_next;
    logic [15:0] crc_hold_reg, crc_hold_next;
    logic [7:0]  flags_left_reg, flags_left_next;
    logic        level_now_reg, level_now_next;
    logic        byte_is_flag_reg, byte_is_flag_next;

    logic        m_valid_reg;
    logic        line_level_reg;
    logic        line_active_reg;
    logic        pop_byte_reg;

    logic        active;
    logic        popped;
    logic        data;
    logic        fb;
    logic        s_accept;

    assign cfg_ready     = 1'b1;
    assign s_ready       = !m_valid_reg || m_ready;
    assign s_accept      = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_line_level  = line_level_reg;
    assign m_line_active = line_active_reg;
    assign m_pop_byte    = pop_byte_reg;

    always_comb begin
        tx_phase_next     = tx_phase_reg;
        shift_byte_next   = shift_byte_reg;
        bits_sent_next    = bits_sent_reg;
        ones_run_next     = ones_run_reg;
        crc_acc_next      = crc_acc_reg;
        crc_hold_next     = crc_hold_reg;
        flags_left_next   = flags_left_reg;
        level_now_next    = level_now_reg;
        byte_is_flag_next = byte_is_flag_reg;
        active            = 1'b1;
        popped            = 1'b0;
        data              = 1'b0;
        fb                = 1'b0;

        if (ones_run_reg == hnt_pkg::STUFF_RUN && !byte_is_flag_reg) begin
            ones_run_next = 3'd0;
        end else begin
            if (bits_sent_reg >= hnt_pkg::BYTE_BITS) begin
                bits_sent_next = 4'd0;
                unique case (tx_phase_reg)
                    hnt_pkg::PH_HEAD: begin
                        flags_left_next = flags_left_reg - 8'd1;
                        if (flags_left_next == 8'd0) begin
                            if (s_queue_empty) begin
                                shift_byte_next   = hnt_pkg::FLAG_BYTE;
                                byte_is_flag_next = 1'b1;
                                tx_phase_next     = hnt_pkg::PH_IDLE;
                            end else begin
                                shift_byte_next   = s_queue_byte;
                                byte_is_flag_next = 1'b0;
                                popped            = 1'b1;
                                crc_acc_next      = hnt_pkg::CRC_PRESET;
                                ones_run_next     = 3'd0;
                                tx_phase_next     = hnt_pkg::PH_FRAME;
                            end
                        end else begin
                            shift_byte_next   = hnt_pkg::FLAG_BYTE;
                            byte_is_flag_next = 1'b1;
                        end
                    end
                    hnt_pkg::PH_FRAME: begin
                        if (s_queue_empty) begin
                            crc_hold_next     = crc_acc_reg;
                            shift_byte_next   = crc_acc_reg[7:0] ^ hnt_pkg::BYTE_MASK;
                            byte_is_flag_next = 1'b0;
                            tx_phase_next     = hnt_pkg::PH_CRC_HI;
                        end else begin
                            shift_byte_next   = s_queue_byte;
                            byte_is_flag_next = 1'b0;
                            popped            = 1'b1;
                            if (s_queue_one_left) begin
                                tx_phase_next = hnt_pkg::PH_CRC_LO;
                            end
                        end
                    end
                    hnt_pkg::PH_CRC_LO: begin
                        crc_hold_next     = crc_acc_reg;
                        shift_byte_next   = crc_acc_reg[7:0] ^ hnt_pkg::BYTE_MASK;
                        byte_is_flag_next = 1'b0;
                        tx_phase_next     = hnt_pkg::PH_CRC_HI;
                    end
                    hnt_pkg::PH_CRC_HI: begin
                        shift_byte_next   = crc_hold_reg[15:8] ^ hnt_pkg::BYTE_MASK;
                        byte_is_flag_next = 1'b0;
                        tx_phase_next     = hnt_pkg::PH_TAIL;
                        flags_left_next   = tail_flags_reg + 8'd1;
                    end
                    hnt_pkg::PH_TAIL: begin
                        if (!s_queue_empty) begin
                            tx_phase_next   = hnt_pkg::PH_HEAD;
                            flags_left_next = 8'd1;
                        end else begin
                            flags_left_next = flags_left_reg - 8'd1;
                            if (flags_left_next == 8'd0) begin
                                tx_phase_next = hnt_pkg::PH_IDLE;
                            end
                        end
                        shift_byte_next   = hnt_pkg::FLAG_BYTE;
                        byte_is_flag_next = 1'b1;
                    end
                    default: begin
                        if (!s_queue_empty) begin
                            tx_phase_next     = hnt_pkg::PH_HEAD;
                            flags_left_next   = head_flags_reg;
                            shift_byte_next   = hnt_pkg::FLAG_BYTE;
                            byte_is_flag_next = 1'b1;
                        end else begin
                            tx_phase_next  = hnt_pkg::PH_IDLE;
                            bits_sent_next = hnt_pkg::BYTE_BITS;
                            active         = 1'b0;
                        end
                    end
                endcase
            end
            if (active) begin
                data = shift_byte_next[0];
                if (data) begin
                    ones_run_next = ones_run_next + 3'd1;
                end
                shift_byte_next = {1'b0, shift_byte_next[7:1]};
                bits_sent_next  = bits_sent_next + 4'd1;
                fb              = crc_acc_next[0] ^ data;
                crc_acc_next    = {1'b0, crc_acc_next[15:1]}
                                ^ (fb ? hnt_pkg::CRC_POLY : 16'd0);
            end
        end

        if (active && !data) begin
            level_now_next = !level_now_reg;
            ones_run_next  = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_flags_reg   <= hnt_pkg::HEAD_FLAGS_RESET;
            tail_flags_reg   <= hnt_pkg::TAIL_FLAGS_RESET;
            tx_phase_reg     <= hnt_pkg::PH_IDLE;
            shift_byte_reg   <= 8'd0;
            bits_sent_reg    <= hnt_pkg::BYTE_BITS;
            ones_run_reg     <= 3'd0;
            crc_acc_reg      <= hnt_pkg::CRC_PRESET;
            crc_hold_reg     <= 16'd0;
            flags_left_reg   <= 8'd0;
            level_now_reg    <= 1'b0;
            byte_is_flag_reg <= 1'b1;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    hnt_pkg::CFG_HEAD_FLAGS: head_flags_reg <= cfg_data;
                    hnt_pkg::CFG_TAIL_FLAGS: tail_flags_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_accept) begin
                tx_phase_reg     <= tx_phase_next;
                shift_byte_reg   <= shift_byte_next;
                bits_sent_reg    <= bits_sent_next;
                ones_run_reg     <= ones_run_next;
                crc_acc_reg      <= crc_acc_next;
                crc_hold_reg     <= crc_hold_next;
                flags_left_reg   <= flags_left_next;
                level_now_reg    <= level_now_next;
                byte_is_flag_reg <= byte_is_flag_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            line_level_reg  <= level_now_next;
            line_active_reg <= active;
            pop_byte_reg    <= popped;
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int CALM_ITEMS  = 200;
    localparam int NUM_PHASES  = 6;

    typedef struct packed {
        logic level;
        logic active;
        logic pop;
    } line_bit_t;

    typedef struct packed {
        logic      q_empty;
        logic      q_one;
        logic [7:0] q_data;
        logic [7:0] reps;
        logic      typed;
        line_bit_t want;
    } stim_row_t;

    typedef struct {
        logic [7:0] head;
        logic [7:0] tail;
        int         items;
    } phase_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_queue_empty = 1'b1;
    logic       s_queue_one_left = 1'b0;
    logic [7:0] s_queue_byte = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_line_level;
    logic       m_line_active;
    logic       m_pop_byte;

    int          cycles = 0;
    int          errors = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    line_bit_t   line_bits_due[$];
    logic [7:0]  pending[$];

    hnt_pkg::tx_phase_t p_phase;
    logic [7:0] p_shift;
    logic [3:0] p_bits;
    logic [2:0] p_ones;
    logic [15:0] p_crc;
    logic [15:0] p_crc_hold;
    logic [7:0] p_flags_left;
    logic       p_level;
    logic       p_is_flag;
    logic [7:0] p_head_cfg;
    logic [7:0] p_tail_cfg;

    stim_row_t directed_rows [6] = '{
        '{1'b1, 1'b0, 8'h00, 8'd1, 1'b1, 3'b000},
        '{1'b1, 1'b1, 8'hFF, 8'd2, 1'b1, 3'b000},
        '{1'b0, 1'b0, 8'hFF, 8'd8, 1'b0, 3'b000},
        '{1'b0, 1'b0, 8'hFF, 8'd1, 1'b0, 3'b000},
        '{1'b0, 1'b0, 8'h00, 8'd8, 1'b0, 3'b000},
        '{1'b1, 1'b0, 8'h00, 8'd1, 1'b0, 3'b000}
    };

    phase_t phases [NUM_PHASES] = '{
        '{8'd1,   8'd1,   300},
        '{8'd1,   8'd0,   250},
        '{8'd2,   8'd3,   250},
        '{8'd1,   8'd255, 250},
        '{8'd3,   8'd2,   200},
        '{8'd0,   8'd254, 250}
    };

    hdlc_nrzi_transmitter uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_queue_empty    (s_queue_empty),
        .s_queue_one_left (s_queue_one_left),
        .s_queue_byte     (s_queue_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_line_level     (m_line_level),
        .m_line_active    (m_line_active),
        .m_pop_byte       (m_pop_byte)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic void load_flag_byte();
        p_shift = hnt_pkg::FLAG_BYTE;
        p_is_flag = 1'b1;
    endfunction

    function automatic void load_crc_low();
        p_crc_hold = p_crc;
        p_shift = p_crc_hold[7:0] ^ hnt_pkg::BYTE_MASK;
        p_is_flag = 1'b0;
        p_phase = hnt_pkg::PH_CRC_HI;
    endfunction

    function automatic line_bit_t predict_line_bit(input logic q_empty, input logic q_one,
                                                   input logic [7:0] q_data);
        line_bit_t r;
        logic      d;
        logic      fb;
        r = '{level: 1'b0, active: 1'b1, pop: 1'b0};
        if (p_ones == hnt_pkg::STUFF_RUN && !p_is_flag) begin
            d = 1'b0;
            p_ones = '0;
        end else begin
            if (p_bits >= hnt_pkg::BYTE_BITS) begin
                p_bits = '0;
                case (p_phase)
                    hnt_pkg::PH_HEAD: begin
                        p_flags_left = p_flags_left - 8'd1;
                        if (p_flags_left == 8'd0) begin
                            if (q_empty) begin
                                load_flag_byte();
                                p_phase = hnt_pkg::PH_IDLE;
                            end else begin
                                p_shift = q_data;
                                p_is_flag = 1'b0;
                                r.pop = 1'b1;
                                p_crc = hnt_pkg::CRC_PRESET;
                                p_ones = '0;
                                p_phase = hnt_pkg::PH_FRAME;
                            end
                        end else begin
                            load_flag_byte();
                        end
                    end
                    hnt_pkg::PH_FRAME: begin
                        if (q_empty) begin
                            load_crc_low();
                        end else begin
                            p_shift = q_data;
                            p_is_flag = 1'b0;
                            r.pop = 1'b1;
                            if (q_one)
                                p_phase = hnt_pkg::PH_CRC_LO;
                        end
                    end
                    hnt_pkg::PH_CRC_LO: begin
                        load_crc_low();
                    end
                    hnt_pkg::PH_CRC_HI: begin
                        p_shift = p_crc_hold[15:8] ^ hnt_pkg::BYTE_MASK;
                        p_is_flag = 1'b0;
                        p_phase = hnt_pkg::PH_TAIL;
                        p_flags_left = p_tail_cfg + 8'd1;
                    end
                    hnt_pkg::PH_TAIL: begin
                        if (!q_empty) begin
                            p_phase = hnt_pkg::PH_HEAD;
                            p_flags_left = 8'd1;
                        end else begin
                            p_flags_left = p_flags_left - 8'd1;
                            if (p_flags_left == 8'd0)
                                p_phase = hnt_pkg::PH_IDLE;
                        end
                        load_flag_byte();
                    end
                    default: begin
                        if (!q_empty) begin
                            p_phase = hnt_pkg::PH_HEAD;
                            p_flags_left = p_head_cfg;
                            load_flag_byte();
                        end else begin
                            p_phase = hnt_pkg::PH_IDLE;
                            p_bits = hnt_pkg::BYTE_BITS;
                            r.level = p_level;
                            r.active = 1'b0;
                            return r;
                        end
                    end
                endcase
            end
            d = p_shift[0];
            if (d)
                p_ones = p_ones + 3'd1;
            p_shift = p_shift >> 1;
            p_bits = p_bits + 4'd1;
            fb = p_crc[0] ^ d;
            p_crc = p_crc >> 1;
            if (fb)
                p_crc = p_crc ^ hnt_pkg::CRC_POLY;
        end
        if (!d) begin
            p_level = ~p_level;
            p_ones = '0;
        end
        r.level = p_level;
        return r;
    endfunction

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == hnt_pkg::CFG_HEAD_FLAGS)
            p_head_cfg = val;
        else
            p_tail_cfg = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_bit_request(input logic q_empty, input logic q_one,
                                    input logic [7:0] q_data, output line_bit_t want);
        @(negedge aclk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_queue_empty <= q_empty;
        s_queue_one_left <= q_one;
        s_queue_byte <= q_data;
        do @(posedge aclk); while (!s_ready);
        want = predict_line_bit(q_empty, q_one, q_data);
    endtask

    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 4;
            default: return 15;
        endcase
    endfunction

    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (line_bits_due.size() == 0) begin
                flag_mismatch("result beat with nothing expected");
            end else begin
                if (m_line_level !== line_bits_due[0].level)
                    flag_mismatch($sformatf("line_level got %b want %b",
                                            m_line_level, line_bits_due[0].level));
                if (m_line_active !== line_bits_due[0].active)
                    flag_mismatch($sformatf("line_active got %b want %b",
                                            m_line_active, line_bits_due[0].active));
                if (m_pop_byte !== line_bits_due[0].pop)
                    flag_mismatch($sformatf("pop_byte got %b want %b",
                                            m_pop_byte, line_bits_due[0].pop));
                void'(line_bits_due.pop_front());
            end
        end
    end

    initial begin
        int        frame_len;
        logic      qe;
        logic      qo;
        logic [7:0] qd;
        logic      noise;
        line_bit_t want;
        stim_row_t row;

        p_phase = hnt_pkg::PH_IDLE;
        p_shift = '0;
        p_bits = hnt_pkg::BYTE_BITS;
        p_ones = '0;
        p_crc = hnt_pkg::CRC_PRESET;
        p_crc_hold = '0;
        p_flags_left = '0;
        p_level = 1'b0;
        p_is_flag = 1'b1;
        p_head_cfg = hnt_pkg::HEAD_FLAGS_RESET;
        p_tail_cfg = hnt_pkg::TAIL_FLAGS_RESET;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            repeat (row.reps) begin
                send_bit_request(row.q_empty, row.q_one, row.q_data, want);
                line_bits_due.push_back(row.typed ? row.want : want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                while (line_bits_due.size() != 0) @(posedge aclk);
                repeat (2) @(posedge aclk);
                write_reg(hnt_pkg::CFG_HEAD_FLAGS, phases[ph].head);
                write_reg(hnt_pkg::CFG_TAIL_FLAGS, phases[ph].tail);
            end
            gap_pct = pick_pct();
            stall_pct = pick_pct();
            for (int n = 0; n < phases[ph].items; n++) begin
                if (ph == NUM_PHASES - 1 && n == phases[ph].items - CALM_ITEMS) begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                if (pending.size() == 0 && $urandom_range(0, 99) < 6) begin
                    frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                                             : $urandom_range(1, 4);
                    repeat (frame_len) begin
                        case ($urandom_range(0, 5))
                            0: pending.push_back(8'hFF);
                            1: pending.push_back(8'h00);
                            2: pending.push_back(hnt_pkg::FLAG_BYTE);
                            default: pending.push_back(8'($urandom));
                        endcase
                    end
                end
                if (pending.size() != 0 && $urandom_range(0, 199) == 0)
                    pending.delete();
                noise = ($urandom_range(0, 19) == 0);
                if (noise) begin
                    qe = 1'($urandom_range(0, 1));
                    qo = 1'($urandom_range(0, 1));
                    qd = 8'($urandom);
                end else begin
                    qe = (pending.size() == 0);
                    qo = (pending.size() == 1);
                    qd = qe ? 8'($urandom) : pending[0];
                end
                send_bit_request(qe, qo, qd, want);
                line_bits_due.push_back(want);
                if (want.pop && !noise && pending.size() != 0)
                    void'(pending.pop_front());
            end
            @(negedge aclk);
            s_valid <= 1'b0;
        end

        while (line_bits_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
